>>> hdl/rfd_pkg.sv
// Shared types, register codes and constants of the radar fall detector.
package rfd_pkg;

  // Frame rate the counter limits are scaled by, in frames per second.
  localparam int FRAME_RATE_HZ_DEFAULT = 10;

  // Score limits in unsigned Q8.8: below 5.0 is a rest frame, above 10.0 breaks a rest run.
  localparam logic [15:0] REST_SCORE_Q88   = 16'd1280;
  localparam logic [15:0] ACTIVE_SCORE_Q88 = 16'd2560;

  // Register values after reset.
  localparam logic [15:0] IMPACT_THR_RESET      = 16'd5120;
  localparam logic [14:0] FALLEN_DIST_RESET     = 15'd200;
  localparam logic [5:0]  CONFIRM_SECONDS_RESET = 6'd5;
  localparam logic [15:0] CANCEL_THR_RESET      = 16'd6400;
  localparam logic        DETECT_ENABLE_RESET   = 1'b1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMPACT_THR      = 3'd0,
    CFG_FALLEN_DIST     = 3'd1,
    CFG_CONFIRM_SECONDS = 3'd2,
    CFG_CANCEL_THR      = 3'd3,
    CFG_DETECT_ENABLE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] impact_score_threshold;
    logic [14:0] fallen_distance_mm;
    logic [5:0]  confirm_seconds;
    logic [15:0] cancel_score_threshold;
    logic        detect_enable;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] motion_score;
    logic [14:0] distance_mm;
  } frame_t;

  typedef enum logic [1:0] {
    MD_NORMAL  = 2'd0,
    MD_SUSPECT = 2'd1,
    MD_ALARM   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_IMPACT    = 2'd1,
    ST_SUSPECTED = 2'd2,
    ST_ALARM     = 2'd3
  } status_t;

endpackage

>>> hdl/radar_fall_detector_fsm.sv
// Top level of the radar fall detector: input register, mode machine and result register.
//
// Each input word is either a sensor frame (cmd 0, with a Q8.8 motion score and a distance
// in millimeters) or a clear request (cmd 1), and each word yields exactly one status word:
// 0 normal, 1 impact, 2 suspected, 3 alarm. A word is captured in an input register, the
// mode machine evaluates it against the current counters once the output register is free,
// and the status lands in the output register as the mode state updates at the same edge.
// One word is accepted every cycle as long as the output side keeps taking results. While a
// result waits in the output register, the captured word stays in the input register and
// in_ready drops in that same cycle (in_ready follows out_ready combinationally), so at most
// two words sit inside the block during a stall. All counter limits are scaled by
// FRAME_RATE_HZ (2 to 100). Configuration writes are always accepted (cfg_ready is high)
// and should only be issued while no word is in flight; unknown register indexes are
// ignored. When detection is disabled, sensor frames report normal and leave all state
// untouched, while clear requests are still honored.
module radar_fall_detector_fsm #(
  parameter int FRAME_RATE_HZ = rfd_pkg::FRAME_RATE_HZ_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [15:0]                     motion_score,
  input  logic [14:0]                     distance_mm,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status
);
  import rfd_pkg::*;

  cfg_t    cfg;
  frame_t  frame;
  logic    frame_valid;
  logic    out_free;
  logic    fire;
  status_t step_status;

  // The output register can take a new status when it is empty or being drained.
  assign out_free = !out_valid || out_ready;
  // The captured word is evaluated and the mode state advances on this edge.
  assign fire     = frame_valid && out_free;
  assign in_ready = !frame_valid || fire;

  rfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfd_step #(
    .FRAME_RATE_HZ (FRAME_RATE_HZ)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .frame       (frame),
    .cfg         (cfg),
    .step_status (step_status)
  );

  // Valid flags of the two register stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        frame_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= frame_valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame.cmd          <= cmd;
      frame.motion_score <= motion_score;
      frame.distance_mm  <= distance_mm;
    end
    if (fire) begin
      status <= step_status;
    end
  end

`ifndef SYNTHESIS
  a_capture_holds: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !fire |=> frame_valid && $stable(frame))
    else $error("captured word lost while the output was stalled");

  a_result_follows_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("evaluated word produced no status");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    out_free && !frame_valid |=> !out_valid)
    else $error("status produced without a captured word");
`endif

endmodule

>>> hdl/rfd_cfg.sv
// Configuration register file of the radar fall detector.
module rfd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rfd_pkg::cfg_t                      cfg
);
  import rfd_pkg::*;

  // Writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.impact_score_threshold <= IMPACT_THR_RESET;
      cfg.fallen_distance_mm     <= FALLEN_DIST_RESET;
      cfg.confirm_seconds        <= CONFIRM_SECONDS_RESET;
      cfg.cancel_score_threshold <= CANCEL_THR_RESET;
      cfg.detect_enable          <= DETECT_ENABLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMPACT_THR:      cfg.impact_score_threshold <= cfg_data;
        CFG_FALLEN_DIST:     cfg.fallen_distance_mm     <= cfg_data[14:0];
        CFG_CONFIRM_SECONDS: cfg.confirm_seconds        <= cfg_data[5:0];
        CFG_CANCEL_THR:      cfg.cancel_score_threshold <= cfg_data;
        CFG_DETECT_ENABLE:   cfg.detect_enable          <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/rfd_step.sv
// Mode machine and saturating counters: one frame or command per advance.
module rfd_step #(
  parameter int FRAME_RATE_HZ = rfd_pkg::FRAME_RATE_HZ_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  rfd_pkg::frame_t  frame,
  input  rfd_pkg::cfg_t    cfg,
  output rfd_pkg::status_t step_status
);
  import rfd_pkg::*;

  localparam logic [15:0] REST_LIMIT     = 16'(5 * FRAME_RATE_HZ);
  localparam logic [7:0]  IMPACT_LIMIT   = 8'(FRAME_RATE_HZ / 2);
  localparam logic [7:0]  RECOVERY_LIMIT = 8'(2 * FRAME_RATE_HZ);
  localparam logic [7:0]  CANCEL_LIMIT   = 8'(FRAME_RATE_HZ);
  localparam logic [15:0] TIMEOUT_LIMIT  = 16'(30 * FRAME_RATE_HZ);

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] dec_two8(input logic [7:0] v);
    return (v > 8'd2) ? v - 8'd2 : 8'd0;
  endfunction

  function automatic logic [15:0] dec_two16(input logic [15:0] v);
    return (v > 16'd2) ? v - 16'd2 : 16'd0;
  endfunction

  mode_t       mode, mode_next;
  logic [7:0]  impact_count, impact_count_next;
  logic [15:0] rest_count, rest_count_next;
  logic [14:0] prefall_distance, prefall_distance_next;
  logic        rested_before, rested_before_next;
  logic [15:0] fallen_count, fallen_count_next;
  logic [7:0]  recovery_count, recovery_count_next;
  logic [7:0]  strong_motion_count, strong_motion_count_next;
  logic [15:0] suspect_total, suspect_total_next;
  logic        impact_report;

  // Shared per-frame terms.
  logic [15:0] rest_upd, total_inc, fallen_inc, confirm_limit, required;
  logic [7:0]  impact_inc, recovery_inc, strong_inc;
  logic [14:0] diff;
  logic        is_impact, at_fallen, in_recovery, strong_motion;

  assign rest_upd = (frame.motion_score < REST_SCORE_Q88) ? sat_inc16(rest_count) :
                    (frame.motion_score > ACTIVE_SCORE_Q88) ? 16'd0 : rest_count;
  assign is_impact  = frame.motion_score > cfg.impact_score_threshold;
  assign impact_inc = sat_inc8(impact_count);

  assign diff = (frame.distance_mm >= prefall_distance) ? frame.distance_mm - prefall_distance
                                                        : prefall_distance - frame.distance_mm;
  assign required    = rested_before ? {cfg.fallen_distance_mm, 1'b0}
                                     : {1'b0, cfg.fallen_distance_mm};
  assign at_fallen   = {1'b0, diff} >= required;
  assign in_recovery = {diff, 1'b0} < required;
  assign confirm_limit = 16'(cfg.confirm_seconds) * 16'(FRAME_RATE_HZ);
  assign total_inc    = sat_inc16(suspect_total);
  assign fallen_inc   = sat_inc16(fallen_count);
  assign recovery_inc = sat_inc8(recovery_count);
  assign strong_motion = frame.motion_score > cfg.cancel_score_threshold;
  assign strong_inc   = sat_inc8(strong_motion_count);

  // Next state.
  always_comb begin
    mode_next                = mode;
    impact_count_next        = impact_count;
    rest_count_next          = rest_count;
    prefall_distance_next    = prefall_distance;
    rested_before_next       = rested_before;
    fallen_count_next        = fallen_count;
    recovery_count_next      = recovery_count;
    strong_motion_count_next = strong_motion_count;
    suspect_total_next       = suspect_total;
    impact_report            = 1'b0;

    if (frame.cmd) begin
      if (mode == MD_ALARM) begin
        mode_next                = MD_NORMAL;
        impact_count_next        = 8'd0;
        fallen_count_next        = 16'd0;
        recovery_count_next      = 8'd0;
        strong_motion_count_next = 8'd0;
        suspect_total_next       = 16'd0;
      end
    end else if (cfg.detect_enable) begin
      case (mode)
        MD_SUSPECT: begin
          suspect_total_next = total_inc;
          if (at_fallen) begin
            fallen_count_next   = fallen_inc;
            recovery_count_next = 8'd0;
          end else if (in_recovery) begin
            recovery_count_next = recovery_inc;
            fallen_count_next   = dec_two16(fallen_count);
          end else begin
            recovery_count_next = 8'd0;
          end

          // The first exit that fires ends the frame; later counters keep their values.
          if (at_fallen && fallen_inc >= confirm_limit) begin
            mode_next = MD_ALARM;
          end else if (in_recovery && !at_fallen && recovery_inc >= RECOVERY_LIMIT) begin
            mode_next = MD_NORMAL;
          end else begin
            strong_motion_count_next = strong_motion ? strong_inc : 8'd0;
            if ((strong_motion && strong_inc >= CANCEL_LIMIT) ||
                total_inc >= TIMEOUT_LIMIT) begin
              mode_next = MD_NORMAL;
            end
          end
        end
        MD_ALARM: ;
        default: begin
          mode_next       = MD_NORMAL;
          rest_count_next = rest_upd;
          if (is_impact) begin
            if (impact_count == 8'd0) begin
              prefall_distance_next = frame.distance_mm;
              rested_before_next    = rest_upd > REST_LIMIT;
            end
            impact_count_next = impact_inc;
            if (impact_inc >= IMPACT_LIMIT) begin
              mode_next                = MD_SUSPECT;
              fallen_count_next        = 16'd0;
              recovery_count_next      = 8'd0;
              strong_motion_count_next = 8'd0;
              suspect_total_next       = 16'd0;
            end else begin
              impact_report = 1'b1;
            end
          end else begin
            impact_count_next = dec_two8(impact_count);
          end
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    if (!frame.cmd && !cfg.detect_enable) begin
      step_status = ST_NORMAL;
    end else if (impact_report) begin
      step_status = ST_IMPACT;
    end else begin
      case (mode_next)
        MD_SUSPECT: step_status = ST_SUSPECTED;
        MD_ALARM:   step_status = ST_ALARM;
        default:    step_status = ST_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MD_NORMAL;
      impact_count        <= 8'd0;
      rest_count          <= 16'd0;
      prefall_distance    <= 15'd0;
      rested_before       <= 1'b0;
      fallen_count        <= 16'd0;
      recovery_count      <= 8'd0;
      strong_motion_count <= 8'd0;
      suspect_total       <= 16'd0;
    end else if (fire) begin
      mode                <= mode_next;
      impact_count        <= impact_count_next;
      rest_count          <= rest_count_next;
      prefall_distance    <= prefall_distance_next;
      rested_before       <= rested_before_next;
      fallen_count        <= fallen_count_next;
      recovery_count      <= recovery_count_next;
      strong_motion_count <= strong_motion_count_next;
      suspect_total       <= suspect_total_next;
    end
  end

`ifndef SYNTHESIS
  a_disabled_holds_mode: assert property (@(posedge clk) disable iff (rst)
    fire && !frame.cmd && !cfg.detect_enable |=> $stable(mode) && $stable(impact_count))
    else $error("disabled frame changed the mode state");

  a_clear_leaves_alarm: assert property (@(posedge clk) disable iff (rst)
    fire && frame.cmd && mode == MD_ALARM |=> mode == MD_NORMAL && impact_count == 8'd0
      && suspect_total == 16'd0)
    else $error("clear command did not leave alarm mode cleanly");

  a_suspect_entry_clean: assert property (@(posedge clk) disable iff (rst)
    mode == MD_SUSPECT && $past(mode) == MD_NORMAL |->
      suspect_total == 16'd0 && fallen_count == 16'd0)
    else $error("suspected mode entered with stale counters");

  a_alarm_from_suspected: assert property (@(posedge clk) disable iff (rst)
    mode == MD_ALARM && $past(mode) != MD_ALARM |-> $past(mode) == MD_SUSPECT)
    else $error("alarm raised without a suspected phase");
`endif

endmodule

>>> tb/sv/radar_fall_detector_fsm_tb.sv
// Self-checking testbench for the radar fall detector mode machine, with a built-in status predictor.
module radar_fall_detector_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  // The block runs at its default frame rate. Every counter limit below scales with it.
  localparam int FRAME_RATE = FRAME_RATE_HZ_DEFAULT;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [15:0] motion_score = '0;
  logic [14:0] distance_mm = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;

  radar_fall_detector_fsm #(
    .FRAME_RATE_HZ(FRAME_RATE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .motion_score(motion_score),
    .distance_mm(distance_mm),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status)
  );

  // A 20 ns clock: low half first, so the first rising edge comes at 10 ns.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Words waiting to be offered, and the status words the predictor expects back, in order.
  frame_t  frame_backlog[$];
  status_t expected_status[$];

  int mismatches = 0;
  int words_checked = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 52;
  int hold_left = 0;

  // Our copy of the configuration registers, kept in step with every accepted write.
  bit [15:0] impact_thr  = IMPACT_THR_RESET;
  bit [14:0] fall_dist   = FALLEN_DIST_RESET;
  bit [5:0]  confirm_sec = CONFIRM_SECONDS_RESET;
  bit [15:0] cancel_thr  = CANCEL_THR_RESET;
  bit        detect_en   = DETECT_ENABLE_RESET;

  // Our copy of the detector state. All counters saturate at all ones.
  mode_t     md = MD_NORMAL;
  bit [7:0]  impact_cnt = '0;
  bit [15:0] rest_cnt = '0;
  bit [14:0] prefall = '0;
  bit        rested = 1'b0;
  bit [15:0] fallen_cnt = '0;
  bit [7:0]  recov_cnt = '0;
  bit [7:0]  strong_cnt = '0;
  bit [15:0] susp_total = '0;

  // Advances the predicted state by one accepted word and returns the status it should produce.
  function automatic status_t predict_status(bit c, bit [15:0] score, bit [14:0] range_mm);
    int unsigned diff;
    int unsigned need;
    // A clear request only acts in alarm mode, and it is honored even while disabled.
    if (c) begin
      if (md == MD_ALARM) begin
        md = MD_NORMAL;
        impact_cnt = '0;
        fallen_cnt = '0;
        recov_cnt = '0;
        strong_cnt = '0;
        susp_total = '0;
      end
      return (md == MD_SUSPECT) ? ST_SUSPECTED : (md == MD_ALARM) ? ST_ALARM : ST_NORMAL;
    end
    // A disabled detector reports normal and leaves every counter alone.
    if (!detect_en) return ST_NORMAL;
    if (md == MD_ALARM) return ST_ALARM;
    if (md == MD_SUSPECT) begin
      if (~&susp_total) susp_total++;
      diff = (range_mm >= prefall) ? range_mm - prefall : prefall - range_mm;
      need = rested ? 2 * fall_dist : fall_dist;
      if (diff >= need) begin
        // Subject sits at the fallen position; a zero confirm time alarms right away.
        if (~&fallen_cnt) fallen_cnt++;
        recov_cnt = '0;
        if (fallen_cnt >= confirm_sec * FRAME_RATE) begin
          md = MD_ALARM;
          return ST_ALARM;
        end
      end else if (2 * diff < need) begin
        // Back near the pre-fall spot: recovery builds up while the fallen count drains by two.
        if (~&recov_cnt) recov_cnt++;
        fallen_cnt = (fallen_cnt > 2) ? fallen_cnt - 2 : '0;
        if (recov_cnt >= 2 * FRAME_RATE) begin
          md = MD_NORMAL;
          return ST_NORMAL;
        end
      end else begin
        recov_cnt = '0;
      end
      if (score > cancel_thr) begin
        if (~&strong_cnt) strong_cnt++;
        if (strong_cnt >= FRAME_RATE) begin
          md = MD_NORMAL;
          return ST_NORMAL;
        end
      end else begin
        strong_cnt = '0;
      end
      // Thirty seconds in suspected mode with no decision gives up.
      if (susp_total >= 30 * FRAME_RATE) begin
        md = MD_NORMAL;
        return ST_NORMAL;
      end
      return ST_SUSPECTED;
    end
    // Normal mode: track rest frames, then impacts.
    if (score < REST_SCORE_Q88) begin
      if (~&rest_cnt) rest_cnt++;
    end else if (score > ACTIVE_SCORE_Q88) begin
      rest_cnt = '0;
    end
    if (score > impact_thr) begin
      // The first impact of a run latches where the subject stood and whether it was resting.
      if (impact_cnt == 0) begin
        prefall = range_mm;
        rested = (rest_cnt > 5 * FRAME_RATE);
      end
      if (~&impact_cnt) impact_cnt++;
      if (impact_cnt >= FRAME_RATE / 2) begin
        // The impact count deliberately survives a later cancel; only a clear resets it.
        md = MD_SUSPECT;
        fallen_cnt = '0;
        recov_cnt = '0;
        strong_cnt = '0;
        susp_total = '0;
        return ST_SUSPECTED;
      end
      return ST_IMPACT;
    end
    // A frame without impact takes two off the impact count.
    impact_cnt = (impact_cnt > 2) ? impact_cnt - 2 : '0;
    return ST_NORMAL;
  endfunction

  function automatic void add_frame(bit c, bit [15:0] score, bit [14:0] range_mm);
    frame_t f;
    f.cmd = c;
    f.motion_score = score;
    f.distance_mm = range_mm;
    frame_backlog.push_back(f);
  endfunction

  // A distance within spread of center, clipped to the 15-bit range.
  function automatic bit [14:0] near(int center, int spread);
    int d;
    d = center + int'($urandom_range(2 * spread, 0)) - spread;
    if (d < 0) d = 0;
    if (d > 32767) d = 32767;
    return d[14:0];
  endfunction

  // A score strictly above thr, or all ones when no score can beat it.
  function automatic bit [15:0] above(bit [15:0] thr);
    return (thr == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(65535, thr + 1));
  endfunction

  // Queues one plausible fall scenario: an optional rest run, an impact burst, a stretch in one
  // of the suspected-mode regimes (fallen, recovering, in between, or thrashing), and a tail
  // that often ends with a clear request. Returns its word count, the clear request always counted.
  function automatic int add_episode();
    int base;
    int n;
    int kind;
    int shift;
    int sgn;
    int span;
    int count;
    int i;
    count = 0;
    base = $urandom_range(32767, 0);
    // Long rest runs can reach past five seconds so the doubled fallen distance gets used.
    n = ($urandom_range(3, 0) == 0) ? $urandom_range(70, 45) : $urandom_range(6, 0);
    for (i = 0; i < n; i++)
      add_frame(1'b0, 16'($urandom_range(REST_SCORE_Q88 - 1, 0)), near(base, 15));
    count += n;
    // Impact burst, now and then with a lost impact frame in the middle.
    n = $urandom_range(7, 3);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0)
        add_frame(1'b0, 16'($urandom_range(impact_thr, 0)), near(base, 15));
      else add_frame(1'b0, above(impact_thr), near(base, 15));
    end
    count += n;
    kind = $urandom_range(3, 0);
    sgn = $urandom_range(1, 0) ? 1 : -1;
    case (kind)
      0: begin
        shift = 2 * fall_dist + $urandom_range(100, 0);
        span = int'(confirm_sec) * FRAME_RATE + int'($urandom_range(12, 0)) - 4;
      end
      1: begin
        shift = fall_dist / 3;
        span = $urandom_range(24, 16);
      end
      2: begin
        // Sometimes stay undecided long enough to hit the suspected-mode timeout.
        shift = fall_dist * 3 / 4;
        span = ($urandom_range(15, 0) == 0) ? 305 : $urandom_range(30, 5);
      end
      default: begin
        shift = $urandom_range(2 * fall_dist, 0);
        span = $urandom_range(12, 6);
      end
    endcase
    if (span < 1) span = 1;
    if (span > 320) span = 320;
    for (i = 0; i < span; i++) begin
      if ($urandom_range(9, 0) == 0) add_frame(1'b0, 16'($urandom), 15'($urandom));
      else add_frame(1'b0, (kind == 3) ? above(cancel_thr) : 16'($urandom_range(cancel_thr, 0)),
                     near(base + sgn * shift, 10));
    end
    count += span;
    n = $urandom_range(4, 0);
    for (i = 0; i < n; i++) add_frame(1'b0, 16'($urandom), near(base, 200));
    if ($urandom_range(2, 0) != 0) add_frame(1'b1, 16'($urandom), 15'($urandom));
    count += n + 1;
    return count;
  endfunction

  // Writes one register and mirrors it into our copy once the write is taken. Called at a
  // rising edge; returns at the edge of acceptance with cfg_valid still high, so the caller
  // either issues the next write or lowers cfg_valid in that same step.
  task automatic write_reg(cfg_idx_t idx, bit [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMPACT_THR:      impact_thr = value;
      CFG_FALLEN_DIST:     fall_dist = value[14:0];
      CFG_CONFIRM_SECONDS: confirm_sec = value[5:0];
      CFG_CANCEL_THR:      cancel_thr = value;
      CFG_DETECT_ENABLE:   detect_en = value[0];
      default: ;
    endcase
  endtask

  // Waits until every queued word went in and every expected status came out, then lets
  // the two-stage pipeline settle. Returns at a rising edge.
  task automatic drain();
    do @(negedge clk); while (frame_backlog.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Driver: predicts on every accepted word, then offers the next one from the backlog unless
  // it decides to idle. A word stays on the port untouched until the block takes it.
  always @(posedge clk) begin : feed
    frame_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_status(cmd, motion_score, distance_mm));
      end
      if (!in_valid || in_ready) begin
        if (frame_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = frame_backlog.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.cmd;
          motion_score <= nxt.motion_score;
          distance_mm <= nxt.distance_mm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every status word taken from the block is matched against the oldest prediction.
  always @(posedge clk) begin : watch
    status_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: status word with nothing expected, expected none, got %0d",
                   $time, status);
        end else begin
          want = expected_status.pop_front();
          if (status !== want) begin
            mismatches <= mismatches + 1;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want, status);
          end
        end
        words_checked <= words_checked + 1;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Back-pressure burst: every 500 status words the receiver refuses output until hold_left is zero
  // again while the driver keeps offering, so the result and input registers fill and in_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_valid && out_ready && words_checked % 500 == 250) begin
      hold_left <= 120;
    end
  end

  initial begin : stimulus
    int k;
    int target;
    int queued;
    bit [15:0] thr_v;
    bit [14:0] dist_v;
    bit [5:0]  conf_v;
    bit [15:0] cancel_v;
    bit        en_v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset configuration.
    add_frame(1'b0, 16'd0, 15'd0);            // rest frame at the lowest values
    add_frame(1'b1, 16'hFFFF, 15'h7FFF);      // clear request while normal does nothing
    add_frame(1'b0, 16'hFFFF, 15'h7FFF);      // single impact at the field maximums
    add_frame(1'b0, 16'd0, 15'd0);            // lost impact drops the count back to zero
    add_frame(1'b0, IMPACT_THR_RESET, 15'd100); // a score equal to the threshold is no impact
    repeat (5) add_frame(1'b0, IMPACT_THR_RESET + 16'd1, 15'd3000); // fifth impact: suspected
    add_frame(1'b1, 16'd0, 15'd0);            // clear request in suspected mode is ignored
    add_frame(1'b0, 16'd0, 15'd0);            // far from the pre-fall spot, fallen count starts
    drain();

    // With a zero confirm time the next fallen-position frame raises the alarm at once.
    write_reg(CFG_CONFIRM_SECONDS, 16'd0);
    cfg_valid <= 1'b0;
    add_frame(1'b0, 16'd0, 15'd3200);         // shift exactly equal to the fallen distance
    add_frame(1'b0, 16'hFFFF, 15'd0);         // alarm holds whatever the frame says
    add_frame(1'b1, 16'd1234, 15'd4321);      // clear request leaves alarm mode
    drain();

    // Disabled detection reports normal, yet a clear request is still taken.
    write_reg(CFG_DETECT_ENABLE, 16'd0);
    cfg_valid <= 1'b0;
    add_frame(1'b0, 16'hFFFF, 15'h7FFF);
    add_frame(1'b1, 16'd0, 15'd0);
    drain();

    // Random phases, each with its own register setting. The first ones pin the extremes.
    for (k = 0; k < 9; k++) begin
      if (k < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 52;
      end else if (k < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k)
        0: begin
          thr_v = IMPACT_THR_RESET; dist_v = FALLEN_DIST_RESET; conf_v = 6'd1;
          cancel_v = CANCEL_THR_RESET; en_v = 1'b1; target = 190;
        end
        1: begin
          thr_v = 16'd0; dist_v = 15'd0; conf_v = 6'd60;
          cancel_v = 16'd0; en_v = 1'b1; target = 140;
        end
        2: begin
          thr_v = 16'hFFFF; dist_v = 15'h7FFF; conf_v = 6'd1;
          cancel_v = 16'hFFFF; en_v = 1'b1; target = 90;
        end
        3: begin
          thr_v = 16'($urandom_range(12000, 1500)); dist_v = 15'($urandom_range(4000, 30));
          conf_v = 6'($urandom_range(3, 1)); cancel_v = 16'($urandom_range(20000, 3000));
          en_v = 1'b0; target = 80;
        end
        default: begin
          thr_v = 16'($urandom_range(12000, 1500)); dist_v = 15'($urandom_range(4000, 30));
          conf_v = 6'($urandom_range(3, 1)); cancel_v = 16'($urandom_range(20000, 3000));
          en_v = 1'b1; target = 210;
        end
      endcase
      drain();
      // The bits above each register's width are junk that the block must drop.
      write_reg(CFG_IMPACT_THR, thr_v);
      write_reg(CFG_FALLEN_DIST, {1'($urandom), dist_v});
      write_reg(CFG_CONFIRM_SECONDS, {10'($urandom), conf_v});
      write_reg(CFG_CANCEL_THR, cancel_v);
      write_reg(CFG_DETECT_ENABLE, {15'($urandom), en_v});
      cfg_valid <= 1'b0;
      queued = 0;
      while (queued < target) begin
        if ($urandom_range(6, 0) == 0) begin
          add_frame($urandom_range(3, 0) == 0, 16'($urandom), 15'($urandom));
          queued++;
        end else begin
          queued += add_episode();
        end
      end
    end
    drain();

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about two thousand words.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rfd_pkg.sv
hdl/rfd_cfg.sv
hdl/rfd_step.sv
hdl/radar_fall_detector_fsm.sv
tb/sv/radar_fall_detector_fsm_tb.sv
